@@ hdl/rrfl_pkg.sv @@
// Shared types, sizes and codes for the register rename free list block.
// Used by the map/ring memory, the state memory, the top level and its checker.
package rrfl_pkg;

  // Register file sizes
  localparam int INT_ARCH_REGS   = 40;
  localparam int FP_ARCH_REGS    = 32;
  localparam int INT_PHYS_REGS   = 80;
  localparam int FP_PHYS_REGS    = 72;
  localparam int FREE_LIST_DEPTH = 40;
  localparam int UNMAPPED_REG    = 31;

  // Field widths
  localparam int ARCH_W = 6;
  localparam int PHYS_W = 7;
  localparam int RIDX_W = (FREE_LIST_DEPTH > 1) ? $clog2(FREE_LIST_DEPTH) : 1;
  localparam int CNT_W  = $clog2(FREE_LIST_DEPTH + 1);

  // Map/ring memory: {region, file, slot}
  localparam int MR_AW    = 2 + ARCH_W;
  localparam int MR_DEPTH = 1 << MR_AW;

  // Physical state memory: {file, physical register}
  localparam int ST_AW    = 1 + PHYS_W;
  localparam int ST_DEPTH = 1 << ST_AW;

  // Physical register states
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_VALID   = 2'd2;

  // Map/ring memory regions
  localparam logic REG_MAP  = 1'b0;
  localparam logic REG_RING = 1'b1;

  // Commands
  localparam logic CMD_RENAME = 1'b0;
  localparam logic CMD_MARK   = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ARCH_W-1:0] src1_arch;
    logic              src1_fp;
    logic [ARCH_W-1:0] src2_arch;
    logic              src2_fp;
    logic [ARCH_W-1:0] dest_arch;
    logic              dest_fp;
    logic [PHYS_W-1:0] done_phys;
    logic              done_fp;
  } rrfl_in_t;

  typedef struct packed {
    logic [PHYS_W-1:0] src1_phys;
    logic [PHYS_W-1:0] src2_phys;
    logic [PHYS_W-1:0] dest_phys;
    logic              freed_valid;
    logic [PHYS_W-1:0] freed_phys;
    logic              no_free;
  } rrfl_out_t;

  typedef struct packed {
    logic              re;
    logic [MR_AW-1:0]  raddr;
    logic              we;
    logic [MR_AW-1:0]  waddr;
    logic [PHYS_W-1:0] wdata;
  } mr_req_t;

  typedef struct packed {
    logic             re;
    logic [ST_AW-1:0] raddr;
    logic             we;
    logic [ST_AW-1:0] waddr;
    logic [1:0]       wdata;
  } st_req_t;

  // Number of architectural registers in a file
  function automatic logic [PHYS_W:0] arch_limit(input logic fp);
    return fp ? (PHYS_W+1)'(FP_ARCH_REGS) : (PHYS_W+1)'(INT_ARCH_REGS);
  endfunction

  // Number of physical registers in a file
  function automatic logic [PHYS_W:0] phys_limit(input logic fp);
    return fp ? (PHYS_W+1)'(FP_PHYS_REGS) : (PHYS_W+1)'(INT_PHYS_REGS);
  endfunction

  // Value of a map or ring entry that was never written
  function automatic logic [PHYS_W-1:0] mr_reset_val(input logic [MR_AW-1:0] addr);
    logic              region;
    logic              fp;
    logic [ARCH_W-1:0] slot;
    region = addr[MR_AW-1];
    fp     = addr[MR_AW-2];
    slot   = addr[ARCH_W-1:0];
    if (region == REG_MAP) begin
      return PHYS_W'(slot);
    end
    return PHYS_W'(arch_limit(fp) + (PHYS_W+1)'(slot));
  endfunction

  // State of a physical register that was never written
  function automatic logic [1:0] st_reset_val(input logic [ST_AW-1:0] addr);
    logic              fp;
    logic [PHYS_W-1:0] phys;
    fp   = addr[ST_AW-1];
    phys = addr[PHYS_W-1:0];
    return ((PHYS_W+1)'(phys) < arch_limit(fp)) ? ST_VALID : ST_FREE;
  endfunction

endpackage

@@ hdl/register_rename_free_list.sv @@
// Register rename stage with integer and floating map tables and free lists.
// Depends on rrfl_pkg, rrfl_map_ring and rrfl_state_mem.
//
// One command is handled at a time. A rename reads the source 1, source 2
// and destination mappings and the free ring head; a rename that allocates
// then writes the ring tail (when the old mapping is freed) and the map.
// These accesses share the map/ring memory and each use its single read or
// write port in a cycle of their own. A mark-valid command only writes the
// state memory. The result sits in an output register, so a waiting result
// does not block the next transfer in; a new result is held back only while
// the previous one is stalled.
// No clearing pass follows reset: written entries are tracked by valid bits.
module register_rename_free_list (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rrfl_pkg::rrfl_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rrfl_pkg::rrfl_out_t out_data
);
  import rrfl_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD_S1   = 4'd1;
  localparam logic [3:0] S_RD_S2   = 4'd2;
  localparam logic [3:0] S_RD_D    = 4'd3;
  localparam logic [3:0] S_RD_HEAD = 4'd4;
  localparam logic [3:0] S_FREE_WR = 4'd5;
  localparam logic [3:0] S_MAP_WR  = 4'd6;
  localparam logic [3:0] S_MARK    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]        state_r,     state_nxt;
  rrfl_in_t          item_r,      item_nxt;
  rrfl_out_t         res_r,       res_nxt;
  rrfl_out_t         out_r,       out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PHYS_W-1:0] oldp_r,      oldp_nxt;
  logic [PHYS_W-1:0] newp_r,      newp_nxt;
  logic [RIDX_W-1:0] head_r [2];
  logic [RIDX_W-1:0] head_nxt [2];
  logic [RIDX_W-1:0] tail_r [2];
  logic [RIDX_W-1:0] tail_nxt [2];
  logic [CNT_W-1:0]  cnt_r [2];
  logic [CNT_W-1:0]  cnt_nxt [2];

  mr_req_t           mr_req;
  st_req_t           st_req;
  logic [PHYS_W-1:0] mr_rdata;
  logic [1:0]        st_rdata;

  logic              dfp;
  logic              s1_in_range;
  logic              s2_in_range;
  logic              d_in_range;
  logic              keep_dest;
  logic              free_old;
  logic [RIDX_W-1:0] head_cur;
  logic [RIDX_W-1:0] tail_cur;

  rrfl_map_ring u_map_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mr_req),
    .rdata (mr_rdata)
  );

  rrfl_state_mem u_state_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .rdata (st_rdata)
  );

  // Decode the held command
  assign dfp         = item_r.dest_fp;
  assign head_cur    = head_r[dfp];
  assign tail_cur    = tail_r[dfp];
  assign s1_in_range = (PHYS_W+1)'(item_r.src1_arch) < arch_limit(item_r.src1_fp);
  assign s2_in_range = (PHYS_W+1)'(item_r.src2_arch) < arch_limit(item_r.src2_fp);
  assign d_in_range  = (PHYS_W+1)'(item_r.dest_arch) < arch_limit(dfp);
  assign keep_dest   = ((item_r.dest_arch == item_r.src1_arch) && (item_r.src1_fp == dfp)) ||
                       ((item_r.dest_arch == item_r.src2_arch) && (item_r.src2_fp == dfp)) ||
                       (item_r.dest_arch == ARCH_W'(UNMAPPED_REG)) || !d_in_range;
  assign free_old    = (oldp_r != PHYS_W'(UNMAPPED_REG)) &&
                       ((PHYS_W+1)'(oldp_r) < phys_limit(dfp)) && (st_rdata == ST_VALID);

  // Sequence the memory accesses of one command
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    oldp_nxt      = oldp_r;
    newp_nxt      = newp_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    mr_req        = '0;
    st_req        = '0;

    // Drop the result once it has been transferred
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          case (in_data.cmd)
            CMD_RENAME: state_nxt = S_RD_S1;
            CMD_MARK:   state_nxt = S_MARK;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end

      S_MARK: begin
        st_req.we    = ((PHYS_W+1)'(item_r.done_phys) < phys_limit(item_r.done_fp));
        st_req.waddr = {item_r.done_fp, item_r.done_phys};
        st_req.wdata = ST_VALID;
        res_nxt      = '0;
        state_nxt    = S_DONE;
      end

      S_RD_S1: begin
        mr_req.re    = 1'b1;
        mr_req.raddr = {REG_MAP, item_r.src1_fp, item_r.src1_arch};
        state_nxt    = S_RD_S2;
      end

      S_RD_S2: begin
        mr_req.re         = 1'b1;
        mr_req.raddr      = {REG_MAP, item_r.src2_fp, item_r.src2_arch};
        res_nxt.src1_phys = s1_in_range ? mr_rdata : '0;
        state_nxt         = S_RD_D;
      end

      S_RD_D: begin
        mr_req.re         = 1'b1;
        mr_req.raddr      = {REG_MAP, dfp, item_r.dest_arch};
        res_nxt.src2_phys = s2_in_range ? mr_rdata : '0;
        state_nxt         = S_RD_HEAD;
      end

      // Hold the old mapping, read the ring head and the old register's state
      S_RD_HEAD: begin
        oldp_nxt     = mr_rdata;
        mr_req.re    = 1'b1;
        mr_req.raddr = {REG_RING, dfp, ARCH_W'(head_cur)};
        st_req.re    = 1'b1;
        st_req.raddr = {dfp, mr_rdata};
        state_nxt    = S_FREE_WR;
      end

      // Decide the allocation; push a valid old mapping at the tail
      S_FREE_WR: begin
        newp_nxt            = mr_rdata;
        res_nxt.freed_valid = 1'b0;
        res_nxt.freed_phys  = '0;
        res_nxt.no_free     = 1'b0;
        if (keep_dest) begin
          res_nxt.dest_phys = d_in_range ? oldp_r : '0;
          state_nxt         = S_DONE;
        end else if (cnt_r[dfp] == '0) begin
          res_nxt.dest_phys = '0;
          res_nxt.no_free   = 1'b1;
          state_nxt         = S_DONE;
        end else begin
          res_nxt.dest_phys = mr_rdata;
          head_nxt[dfp]     = (head_cur == RIDX_W'(FREE_LIST_DEPTH - 1)) ?
                              '0 : head_cur + 1'b1;
          if (free_old) begin
            mr_req.we           = 1'b1;
            mr_req.waddr        = {REG_RING, dfp, ARCH_W'(tail_cur)};
            mr_req.wdata        = oldp_r;
            st_req.we           = 1'b1;
            st_req.waddr        = {dfp, oldp_r};
            st_req.wdata        = ST_FREE;
            tail_nxt[dfp]       = (tail_cur == RIDX_W'(FREE_LIST_DEPTH - 1)) ?
                                  '0 : tail_cur + 1'b1;
            res_nxt.freed_valid = 1'b1;
            res_nxt.freed_phys  = oldp_r;
          end else begin
            cnt_nxt[dfp] = cnt_r[dfp] - 1'b1;
          end
          state_nxt = S_MAP_WR;
        end
      end

      // Install the new mapping and mark it pending
      S_MAP_WR: begin
        mr_req.we    = 1'b1;
        mr_req.waddr = {REG_MAP, dfp, item_r.dest_arch};
        mr_req.wdata = newp_r;
        st_req.we    = ((PHYS_W+1)'(newp_r) < phys_limit(dfp));
        st_req.waddr = {dfp, newp_r};
        st_req.wdata = ST_PENDING;
        state_nxt    = S_DONE;
      end

      // Load the output register when it is free or being transferred
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      cnt_r       <= '{default: CNT_W'(FREE_LIST_DEPTH)};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    oldp_r <= oldp_nxt;
    newp_r <= newp_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hdl/rrfl_map_ring.sv @@
// Map table and free ring storage for both register files in one memory.
// One read and one write port, registered read data. Depends on rrfl_pkg.
module rrfl_map_ring (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rrfl_pkg::mr_req_t         req,
  output logic [rrfl_pkg::PHYS_W-1:0] rdata
);
  import rrfl_pkg::*;

  logic [PHYS_W-1:0] mem_r [MR_DEPTH];
  logic [MR_DEPTH-1:0] vld_r;
  logic [PHYS_W-1:0] q_r;
  logic              q_vld_r;
  logic [MR_AW-1:0]  q_addr_r;

  // Write and read the array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      q_r      <= mem_r[req.raddr];
      q_addr_r <= req.raddr;
    end
  end

  // Track written entries; reset clears them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        q_vld_r <= vld_r[req.raddr];
      end
    end
  end

  // Unwritten entries read as their reset contents
  assign rdata = q_vld_r ? q_r : mr_reset_val(q_addr_r);

endmodule

@@ hdl/rrfl_state_mem.sv @@
// Per physical register state (free, pending, valid) for both register files.
// One read and one write port, registered read data. Depends on rrfl_pkg.
module rrfl_state_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  rrfl_pkg::st_req_t req,
  output logic [1:0]        rdata
);
  import rrfl_pkg::*;

  logic [1:0]          mem_r [ST_DEPTH];
  logic [ST_DEPTH-1:0] vld_r;
  logic [1:0]          q_r;
  logic                q_vld_r;
  logic [ST_AW-1:0]    q_addr_r;

  // Write and read the array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      q_r      <= mem_r[req.raddr];
      q_addr_r <= req.raddr;
    end
  end

  // Track written entries; reset clears them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        q_vld_r <= vld_r[req.raddr];
      end
    end
  end

  // Unwritten entries read as their reset state
  assign rdata = q_vld_r ? q_r : st_reset_val(q_addr_r);

endmodule

@@ hdl/rrfl_checker.sv @@
// Port-level checks for register_rename_free_list, attached by bind.
// Depends on rrfl_pkg.
module rrfl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rrfl_pkg::rrfl_out_t out_data
);
  import rrfl_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One command at a time: a transfer in closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a command is in flight");

  // A refused rename allocates and frees nothing
  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_free |->
      !out_data.freed_valid && (out_data.dest_phys == '0))
    else $error("refused rename reports an allocation");

  // The unmapped marker is never returned to a free list
  a_freed_not_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.freed_valid |->
      (out_data.freed_phys != PHYS_W'(UNMAPPED_REG)))
    else $error("unmapped marker freed");

  // Without a freed register the freed field reads zero
  a_freed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.freed_valid |-> (out_data.freed_phys == '0))
    else $error("freed register reported without freed flag");

endmodule

bind register_rename_free_list rrfl_checker u_rrfl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ test/register_rename_free_list_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for register_rename_free_list: random and directed
// instruction streams, a local map/free-list predictor and a result scoreboard.
// Depends on rrfl_pkg and the register_rename_free_list RTL.
module register_rename_free_list_tb;
  import rrfl_pkg::*;

  localparam int PLAN_CTX         = 0;  // state copy used while building stimulus
  localparam int CHECK_CTX        = 1;  // state copy advanced on each accepted transfer
  localparam int LEAK_PCT         = 2;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int SETTLE_CYCLES    = 16;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  rrfl_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rrfl_out_t out_data;

  // Predictor state, one copy per context, indexed [ctx][file]
  logic [PHYS_W-1:0] arch_map   [2][2][64];
  logic [1:0]        phys_state [2][2][128];
  logic [PHYS_W-1:0] free_ring  [2][2][FREE_LIST_DEPTH];
  int                ring_head  [2][2];
  int                ring_tail  [2][2];
  int                ring_count [2][2];

  rrfl_in_t        instr_queue[$];
  rrfl_out_t       expected_renames[$];
  logic [PHYS_W:0] unmarked_regs[$];  // {fp, phys} allocated and not yet marked valid

  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  bit        send_hold     = 1'b0;
  int        hold_requests = 0;
  int        holds_served  = 0;
  int        rx_hold_left  = 0;
  int        idle_cycles   = 0;
  int        mismatch_count = 0;
  rrfl_out_t next_result;
  rrfl_out_t want_result;
  logic      check_alloc;

  register_rename_free_list dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int file_arch_regs(input logic fp);
    return fp ? FP_ARCH_REGS : INT_ARCH_REGS;
  endfunction

  function automatic int file_phys_regs(input logic fp);
    return fp ? FP_PHYS_REGS : INT_PHYS_REGS;
  endfunction

  task automatic init_rename_state(input int ctx);
    for (int f = 0; f < 2; f++) begin
      for (int a = 0; a < 64; a++) arch_map[ctx][f][a] = PHYS_W'(a);
      for (int p = 0; p < 128; p++)
        phys_state[ctx][f][p] = (p < file_arch_regs(f[0])) ? ST_VALID : ST_FREE;
      for (int i = 0; i < FREE_LIST_DEPTH; i++)
        free_ring[ctx][f][i] = PHYS_W'(file_arch_regs(f[0]) + i);
      ring_head[ctx][f]  = 0;
      ring_tail[ctx][f]  = 0;
      ring_count[ctx][f] = FREE_LIST_DEPTH;
    end
  endtask

  function automatic logic [PHYS_W-1:0] map_lookup(input int ctx, input logic fp,
                                                   input logic [ARCH_W-1:0] arch);
    return (arch < file_arch_regs(fp)) ? arch_map[ctx][fp][arch] : '0;
  endfunction

  // Rename or mark one instruction against the given state copy
  function automatic rrfl_out_t rename_apply(input int ctx, input rrfl_in_t it,
                                             output logic allocated);
    rrfl_out_t         r;
    logic [PHYS_W-1:0] newp;
    logic [PHYS_W-1:0] oldp;
    logic              f;
    r = '0;
    allocated = 1'b0;
    f = it.dest_fp;
    if (it.cmd == CMD_MARK) begin
      if (it.done_phys < file_phys_regs(it.done_fp))
        phys_state[ctx][it.done_fp][it.done_phys] = ST_VALID;
    end else begin
      r.src1_phys = map_lookup(ctx, it.src1_fp, it.src1_arch);
      r.src2_phys = map_lookup(ctx, it.src2_fp, it.src2_arch);
      if ((it.dest_arch == it.src1_arch && it.src1_fp == f) ||
          (it.dest_arch == it.src2_arch && it.src2_fp == f) ||
          it.dest_arch == UNMAPPED_REG || it.dest_arch >= file_arch_regs(f)) begin
        // keep the current mapping
        r.dest_phys = map_lookup(ctx, f, it.dest_arch);
      end else if (ring_count[ctx][f] == 0) begin
        r.no_free = 1'b1;
      end else begin
        newp = free_ring[ctx][f][ring_head[ctx][f]];
        oldp = arch_map[ctx][f][it.dest_arch];
        ring_head[ctx][f]  = (ring_head[ctx][f] + 1) % FREE_LIST_DEPTH;
        ring_count[ctx][f] = ring_count[ctx][f] - 1;
        // return a valid old mapping; drop a pending one
        if (oldp != UNMAPPED_REG && oldp < file_phys_regs(f) &&
            phys_state[ctx][f][oldp] == ST_VALID) begin
          free_ring[ctx][f][ring_tail[ctx][f]] = oldp;
          ring_tail[ctx][f]  = (ring_tail[ctx][f] + 1) % FREE_LIST_DEPTH;
          ring_count[ctx][f] = ring_count[ctx][f] + 1;
          phys_state[ctx][f][oldp] = ST_FREE;
          r.freed_valid = 1'b1;
          r.freed_phys  = oldp;
        end
        arch_map[ctx][f][it.dest_arch] = newp;
        if (newp < file_phys_regs(f)) phys_state[ctx][f][newp] = ST_PENDING;
        r.dest_phys = newp;
        allocated = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [ARCH_W-1:0] random_src();
    return ($urandom_range(9) == 0) ? ARCH_W'(UNMAPPED_REG)
                                    : ARCH_W'($urandom_range(INT_ARCH_REGS - 1));
  endfunction

  function automatic rrfl_in_t random_fields();
    rrfl_in_t it;
    it.cmd       = CMD_RENAME;
    it.src1_arch = random_src();
    it.src1_fp   = 1'($urandom_range(1));
    it.src2_arch = random_src();
    it.src2_fp   = 1'($urandom_range(1));
    it.dest_arch = ARCH_W'($urandom_range(INT_ARCH_REGS - 1));
    it.dest_fp   = 1'($urandom_range(1));
    it.done_phys = PHYS_W'($urandom_range(INT_PHYS_REGS - 1));
    it.done_fp   = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic rrfl_in_t rename_item(input int s1, input logic s1fp, input int s2,
                                           input logic s2fp, input int d, input logic dfp);
    rrfl_in_t it;
    it = random_fields();
    it.src1_arch = ARCH_W'(s1);
    it.src1_fp   = s1fp;
    it.src2_arch = ARCH_W'(s2);
    it.src2_fp   = s2fp;
    it.dest_arch = ARCH_W'(d);
    it.dest_fp   = dfp;
    return it;
  endfunction

  function automatic rrfl_in_t mark_item(input int phys, input logic fp);
    rrfl_in_t it;
    it = random_fields();
    it.cmd       = CMD_MARK;
    it.done_phys = PHYS_W'(phys);
    it.done_fp   = fp;
    return it;
  endfunction

  // Advance the planning copy and remember fresh registers for a later mark
  task automatic queue_item(input rrfl_in_t it, input bit track);
    rrfl_out_t r;
    logic      alloc;
    r = rename_apply(PLAN_CTX, it, alloc);
    if (track && alloc && $urandom_range(99) >= LEAK_PCT)
      unmarked_regs.push_back({it.dest_fp, r.dest_phys});
    instr_queue.push_back(it);
  endtask

  // Mostly rename/mark pairs on live registers; drain mode only renames a few
  // destinations so pending registers get dropped and the free lists run dry
  task automatic queue_random_item(input bit drain);
    rrfl_in_t          it;
    int                roll;
    int                pick;
    logic [PHYS_W:0]   reg_id;
    logic [ARCH_W-1:0] d;
    it = random_fields();
    roll = $urandom_range(99);
    if (!drain && unmarked_regs.size() != 0 && roll < 45) begin
      pick = ($urandom_range(3) == 0) ? $urandom_range(unmarked_regs.size() - 1) : 0;
      reg_id = unmarked_regs[pick];
      unmarked_regs.delete(pick);
      it.cmd       = CMD_MARK;
      it.done_fp   = reg_id[PHYS_W];
      it.done_phys = reg_id[PHYS_W-1:0];
    end else if (!drain && roll < 52) begin
      it.cmd = CMD_MARK;
    end else begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        it.dest_arch = ARCH_W'(UNMAPPED_REG);
      end else if (pick < 14) begin
        it.dest_arch = it.src1_arch;
        it.dest_fp   = it.src1_fp;
      end else if (pick >= 14 && pick < 18) begin
        it.dest_arch = it.src2_arch;
        it.dest_fp   = it.src2_fp;
      end else if (pick >= 22) begin
        d = '0;
        for (int tries = 0; tries < 8; tries++) begin
          d = drain ? ARCH_W'($urandom_range(7))
                    : ARCH_W'($urandom_range(file_arch_regs(it.dest_fp) - 1));
          if (d != UNMAPPED_REG &&
              (drain || phys_state[PLAN_CTX][it.dest_fp][arch_map[PLAN_CTX][it.dest_fp][d]]
                        == ST_VALID))
            break;
        end
        it.dest_arch = d;
      end
    end
    queue_item(it, !drain);
  endtask

  task automatic queue_directed();
    queue_item(rename_item(0, 0, 39, 0, 1, 0), 1);                // allocate, free identity
    queue_item(rename_item(0, 1, UNMAPPED_REG, 1, 5, 1), 1);      // floating allocate
    queue_item(rename_item(7, 0, 3, 1, 7, 0), 1);                 // dest equals source 1
    queue_item(rename_item(4, 0, 9, 1, 9, 1), 1);                 // dest equals source 2
    queue_item(rename_item(12, 1, UNMAPPED_REG, 0, 12, 0), 1);    // same number, other file
    queue_item(rename_item(6, 0, 6, 0, UNMAPPED_REG, 0), 1);      // no destination
    queue_item(rename_item(39, 1, 35, 1, 35, 1), 1);              // beyond floating map
    queue_item(rename_item(1, 0, 5, 1, 36, 1), 1);
    queue_item(mark_item(40, 0), 0);
    queue_item(rename_item(2, 0, 3, 0, 1, 0), 1);                 // old mapping valid again
    queue_item(rename_item(10, 0, 11, 0, 2, 0), 1);
    queue_item(rename_item(10, 0, 11, 0, 2, 0), 1);               // old mapping pending
    queue_item(mark_item(79, 1), 0);                              // beyond floating file
    queue_item(mark_item(FP_PHYS_REGS, 1), 0);
    queue_item(mark_item(0, 0), 0);
    queue_item(mark_item(FP_PHYS_REGS - 1, 1), 0);
    queue_item(mark_item(INT_PHYS_REGS - 1, 0), 0);
    queue_item(rename_item(0, 0, 0, 0, 0, 0), 1);
    queue_item(rename_item(39, 1, 39, 1, 39, 1), 1);
    queue_item(rename_item(UNMAPPED_REG, 0, 39, 0, 39, 0), 1);
    queue_item(rename_item(UNMAPPED_REG, 1, UNMAPPED_REG, 1, UNMAPPED_REG, 1), 1);
    queue_item(mark_item(5, 1), 0);
    queue_item(rename_item(0, 0, UNMAPPED_REG, 1, 0, 1), 1);
  endtask

  task automatic set_idling(input int send_pct, input int rx_pct);
    send_idle_pct = send_pct;
    stall_pct     = rx_pct;
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (instr_queue.size() != 0 || in_valid || expected_renames.size() != 0);
  endtask

  // Driver: predict on each transfer, then offer the next instruction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_result = rename_apply(CHECK_CTX, in_data, check_alloc);
        expected_renames.push_back(next_result);
      end
      if (!in_valid || !in_stall) begin
        if (instr_queue.size() != 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          in_data  <= instr_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      rx_hold_left <= 0;
    end else if (rx_hold_left != 0) begin
      out_stall    <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall    <= 1'b1;
      rx_hold_left <= LONG_HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_renames.size() == 0) begin
        $error("result with no instruction outstanding: %h", out_data);
        mismatch_count++;
      end else begin
        want_result = expected_renames.pop_front();
        check_field("src1_phys", 8'(want_result.src1_phys), 8'(out_data.src1_phys));
        check_field("src2_phys", 8'(want_result.src2_phys), 8'(out_data.src2_phys));
        check_field("dest_phys", 8'(want_result.dest_phys), 8'(out_data.dest_phys));
        check_field("freed_valid", 8'(want_result.freed_valid), 8'(out_data.freed_valid));
        check_field("freed_phys", 8'(want_result.freed_phys), 8'(out_data.freed_phys));
        check_field("no_free", 8'(want_result.no_free), 8'(out_data.no_free));
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus phases
  initial begin
    init_rename_state(PLAN_CTX);
    init_rename_state(CHECK_CTX);
    wait (rst_n);
    @(negedge clk);

    set_idling(0, 0);
    queue_directed();
    wait_quiet();

    set_idling(0, 0);
    repeat (270) queue_random_item(1'b0);
    wait_quiet();

    set_idling(81, 0);
    repeat (270) queue_random_item(1'b0);
    wait_quiet();

    set_idling(0, 81);
    repeat (270) queue_random_item(1'b0);
    wait_quiet();

    set_idling(19, 19);
    repeat (270) queue_random_item(1'b0);
    wait_quiet();

    // back up the block with a long receiver hold, then pause the sender
    set_idling(0, 0);
    repeat (120) queue_random_item(1'b0);
    hold_requests = hold_requests + 1;
    while (instr_queue.size() > 60) @(negedge clk);
    send_hold = 1'b1;
    do @(negedge clk);
    while (in_valid || expected_renames.size() != 0);
    send_hold = 1'b0;
    wait_quiet();

    // run both free lists dry and keep renaming against them
    set_idling(19, 19);
    repeat (170) queue_random_item(1'b1);
    wait_quiet();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
